>>> rtl/obb_pkg.sv
// Shared types, constants and helper functions for the oriented-box overlap test.
// Standalone package; every module of the block imports it.
package obb_pkg;

	localparam int INDEX_BITS = 10;
	localparam int ADDR_BITS  = 6;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = 2;

	// Register byte addresses (8-byte spacing, 64-bit data).
	typedef enum logic [ADDR_BITS-1:0] {
		REG_CENTER_X = 6'd0,
		REG_CENTER_Y = 6'd8,
		REG_CENTER_Z = 6'd16,
		REG_AXIS_0   = 6'd24,
		REG_AXIS_1   = 6'd32,
		REG_AXIS_2   = 6'd40,
		REG_EXTENTS  = 6'd48
	} reg_addr_t;

	typedef struct packed {
		logic signed [23:0] cx, cy, cz;
		logic [47:0]        ax0, ax1, ax2;
		logic [47:0]        ext;
	} box_t;

	// Word passed from the front part to the back part.
	typedef struct packed {
		logic                         enabled;
		logic [INDEX_BITS-1:0]        index;
		logic                         last;
		logic [8:0][17:0]             c_mag;   // rounded |c| per pair, i*3+j
		logic [8:0]                   c_neg;   // sign of c per pair
		logic                         parallel;
		logic [2:0][48:0]             d;       // signed Q.14 projections on ref axes
		logic [2:0][48:0]             dc;      // signed Q.14 projections on cand axes
		logic [47:0]                  e;
		logic [47:0]                  f;
	} work_t;

	// Component k of a packed axis.
	function automatic logic signed [15:0] comp(input logic [47:0] a, input int k);
		comp = a[16*k +: 16];
	endfunction

	function automatic logic [15:0] ext_of(input logic [47:0] p, input int k);
		ext_of = p[16*k +: 16];
	endfunction

endpackage

>>> rtl/obb_overlap_test.sv
// Oriented-box overlap test, 15-axis separating-axis check against a reference box.
// An accepted word passes front stages 1 and 2, the queue, back stage 1 and the output register.
// Throughput one word per cycle when nothing stalls; four pipeline registers plus a 4-entry queue.
// Reset clears all valids and queue pointers; reference box resets to unit axes.
// Depends on obb_pkg, obb_front, obb_queue, obb_back.
module obb_overlap_test (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [obb_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [23:0]             cand_center_x,
	input  logic signed [23:0]             cand_center_y,
	input  logic signed [23:0]             cand_center_z,
	input  logic [47:0]                    cand_axis_0,
	input  logic [47:0]                    cand_axis_1,
	input  logic [47:0]                    cand_axis_2,
	input  logic [47:0]                    cand_extents,
	input  logic                           cand_enabled,
	input  logic [obb_pkg::INDEX_BITS-1:0] cand_index,
	input  logic                           cand_last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           overlap,
	output logic [obb_pkg::INDEX_BITS-1:0] hit_index,
	output logic                           scan_end
);
	import obb_pkg::*;

	box_t  ref_q, cand;
	work_t fw, qw;
	logic  fv, fs, qv, qs, wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// write reference registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q.cx  <= '0;
			ref_q.cy  <= '0;
			ref_q.cz  <= '0;
			ref_q.ax0 <= 48'd16384;
			ref_q.ax1 <= 48'd16384 << 16;
			ref_q.ax2 <= 48'd16384 << 32;
			ref_q.ext <= '0;
		end else if (wr_en) begin
			case (paddr)
				REG_CENTER_X: ref_q.cx  <= pwdata[23:0];
				REG_CENTER_Y: ref_q.cy  <= pwdata[23:0];
				REG_CENTER_Z: ref_q.cz  <= pwdata[23:0];
				REG_AXIS_0:   ref_q.ax0 <= pwdata[47:0];
				REG_AXIS_1:   ref_q.ax1 <= pwdata[47:0];
				REG_AXIS_2:   ref_q.ax2 <= pwdata[47:0];
				REG_EXTENTS:  ref_q.ext <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr)
			REG_CENTER_X: prdata = 64'($unsigned(ref_q.cx));
			REG_CENTER_Y: prdata = 64'($unsigned(ref_q.cy));
			REG_CENTER_Z: prdata = 64'($unsigned(ref_q.cz));
			REG_AXIS_0:   prdata = 64'(ref_q.ax0);
			REG_AXIS_1:   prdata = 64'(ref_q.ax1);
			REG_AXIS_2:   prdata = 64'(ref_q.ax2);
			REG_EXTENTS:  prdata = 64'(ref_q.ext);
			default:      prdata = '0;
		endcase
	end

	assign cand.cx  = cand_center_x;
	assign cand.cy  = cand_center_y;
	assign cand.cz  = cand_center_z;
	assign cand.ax0 = cand_axis_0;
	assign cand.ax1 = cand_axis_1;
	assign cand.ax2 = cand_axis_2;
	assign cand.ext = cand_extents;

	obb_front u_front (
		.clk, .arst_n, .ref_box(ref_q), .in_valid, .in_stall, .cand,
		.cand_enabled, .cand_index, .cand_last,
		.wk_valid(fv), .wk_stall(fs), .wk(fw)
	);

	obb_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_stall(fs), .wr_word(fw),
		.rd_valid(qv), .rd_stall(qs), .rd_word(qw)
	);

	obb_back u_back (
		.clk, .arst_n, .wk_valid(qv), .wk_stall(qs), .wk(qw),
		.out_valid, .out_stall, .overlap, .hit_index, .scan_end
	);

endmodule

>>> rtl/obb_front.sv
// Front part: accepts candidate words, forms dot products and projections.
// Two pipeline stages with per-stage stall; depends on obb_pkg.
module obb_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  obb_pkg::box_t                ref_box,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  obb_pkg::box_t                cand,
	input  logic                         cand_enabled,
	input  logic [obb_pkg::INDEX_BITS-1:0] cand_index,
	input  logic                         cand_last,
	output logic                         wk_valid,
	input  logic                         wk_stall,
	output obb_pkg::work_t               wk
);
	import obb_pkg::*;

	// stage 1 registers: raw full dot products and diff
	logic                   v_s1;
	logic                   en_s1, last_s1;
	logic [INDEX_BITS-1:0]  idx_s1;
	logic signed [33:0]     full_s1 [9];
	logic signed [24:0]     diff_s1 [3];
	logic [47:0]            ax_s1 [3];
	logic [47:0]            bx_s1 [3];
	logic [47:0]            e_s1, f_s1;

	logic adv_s1, adv_s2, v_s2;
	work_t wk_s2;

	function automatic logic [47:0] ref_ax(input int i);
		case (i)
			0:       ref_ax = ref_box.ax0;
			1:       ref_ax = ref_box.ax1;
			default: ref_ax = ref_box.ax2;
		endcase
	endfunction

	function automatic logic [47:0] cand_ax(input int j);
		case (j)
			0:       cand_ax = cand.ax0;
			1:       cand_ax = cand.ax1;
			default: cand_ax = cand.ax2;
		endcase
	endfunction

	function automatic logic signed [33:0] ref_dot(input int i, input int j);
		logic [47:0] a, b;
		a = ref_ax(i);
		b = cand_ax(j);
		ref_dot = 34'(comp(a, 0)) * 34'(comp(b, 0)) + 34'(comp(a, 1)) * 34'(comp(b, 1))
			+ 34'(comp(a, 2)) * 34'(comp(b, 2));
	endfunction

	assign adv_s2   = !v_s2 || !wk_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// advance stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	// compute axis dot products and center difference
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			en_s1   <= cand_enabled;
			last_s1 <= cand_last;
			idx_s1  <= cand_index;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					full_s1[i*3+j] <= ref_dot(i, j);
				end
			end
			diff_s1[0] <= 25'(ref_box.cx) - 25'(cand.cx);
			diff_s1[1] <= 25'(ref_box.cy) - 25'(cand.cy);
			diff_s1[2] <= 25'(ref_box.cz) - 25'(cand.cz);
			ax_s1[0] <= ref_box.ax0;
			ax_s1[1] <= ref_box.ax1;
			ax_s1[2] <= ref_box.ax2;
			bx_s1[0] <= cand.ax0;
			bx_s1[1] <= cand.ax1;
			bx_s1[2] <= cand.ax2;
			e_s1 <= ref_box.ext;
			f_s1 <= cand.ext;
		end
	end

	// stage 2: round c, project diff onto both axis sets
	always_comb begin
		logic [33:0] m;
		logic [33:0] r;
		wk_s2 = '0;
		wk_s2.enabled = en_s1;
		wk_s2.index   = idx_s1;
		wk_s2.last    = last_s1;
		wk_s2.e       = e_s1;
		wk_s2.f       = f_s1;
		for (int p = 0; p < 9; p++) begin
			m = full_s1[p][33] ? 34'(-full_s1[p]) : 34'(full_s1[p]);
			r = (m + 34'd8192) >> 14;
			wk_s2.c_mag[p] = r[17:0];
			wk_s2.c_neg[p] = full_s1[p][33];
			if (r >= 34'd16384) wk_s2.parallel = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			wk_s2.d[i] = 49'(diff_s1[0]) * 49'(comp(ax_s1[i], 0))
				+ 49'(diff_s1[1]) * 49'(comp(ax_s1[i], 1))
				+ 49'(diff_s1[2]) * 49'(comp(ax_s1[i], 2));
			wk_s2.dc[i] = 49'(diff_s1[0]) * 49'(comp(bx_s1[i], 0))
				+ 49'(diff_s1[1]) * 49'(comp(bx_s1[i], 1))
				+ 49'(diff_s1[2]) * 49'(comp(bx_s1[i], 2));
		end
	end

	// hold stage 2 output until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			wk <= wk_s2;
		end
	end

	assign wk_valid = v_s2;

endmodule

>>> rtl/obb_queue.sv
// Short queue of work words between the front and back parts.
// Register-based FIFO; depends on obb_pkg.
module obb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  obb_pkg::work_t wr_word,
	output logic           rd_valid,
	input  logic           rd_stall,
	output obb_pkg::work_t rd_word
);
	import obb_pkg::*;

	work_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 push, pop;

	assign wr_stall = (cnt_q == (QPTR_BITS+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;
	assign rd_word  = mem_q[rp_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_word;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue overflow");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("bad pop count");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("bad push count");

endmodule

>>> rtl/obb_back.sv
// Back part: radii, face and cross axis tests, and the result register.
// Two stages with skid-free stall; depends on obb_pkg.
module obb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wk_valid,
	output logic                           wk_stall,
	input  obb_pkg::work_t                 wk,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           overlap,
	output logic [obb_pkg::INDEX_BITS-1:0] hit_index,
	output logic                           scan_end
);
	import obb_pkg::*;

	logic v_s1, adv_s1, adv_o;
	logic en_s1, last_s1, par_s1, face_ok_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic signed [66:0] cp_s1 [9];
	logic [35:0]        cr_s1 [9];
	logic               cross_ok;

	assign adv_o    = !out_valid || !out_stall;
	assign adv_s1   = !v_s1 || adv_o;
	assign wk_stall = !adv_s1;

	function automatic logic [33:0] em(input logic [47:0] p, input int k,
			input logic [17:0] c);
		em = 34'(ext_of(p, k)) * 34'(c);
	endfunction

	function automatic logic signed [66:0] sc(input logic [8:0][17:0] cm,
			input logic [8:0] cn, input int p);
		sc = cn[p] ? -67'(cm[p]) : 67'(cm[p]);
	endfunction

	// stage 1: face tests and cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= wk_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic ok;
		logic [48:0] md;
		logic [35:0] rs;
		int a1, a2, j1, j2;
		if (adv_s1 && wk_valid) begin
			ok = 1'b1;
			for (int i = 0; i < 3; i++) begin
				md = wk.d[i][48] ? 49'(-wk.d[i]) : wk.d[i];
				rs = 36'(em(wk.f, 0, wk.c_mag[i*3])) + 36'(em(wk.f, 1, wk.c_mag[i*3+1]))
					+ 36'(em(wk.f, 2, wk.c_mag[i*3+2])) + (36'(ext_of(wk.e, i)) << 14);
				if (md > 49'(rs)) ok = 1'b0;
				md = wk.dc[i][48] ? 49'(-wk.dc[i]) : wk.dc[i];
				rs = 36'(em(wk.e, 0, wk.c_mag[i])) + 36'(em(wk.e, 1, wk.c_mag[3+i]))
					+ 36'(em(wk.e, 2, wk.c_mag[6+i])) + (36'(ext_of(wk.f, i)) << 14);
				if (md > 49'(rs)) ok = 1'b0;
			end
			for (int i = 0; i < 3; i++) begin
				a1 = (i + 1) % 3;
				a2 = (i + 2) % 3;
				for (int j = 0; j < 3; j++) begin
					j1 = (j + 1) % 3;
					j2 = (j + 2) % 3;
					cp_s1[i*3+j] <= 67'($signed(wk.d[a2])) * sc(wk.c_mag, wk.c_neg, a1*3+j)
						- 67'($signed(wk.d[a1])) * sc(wk.c_mag, wk.c_neg, a2*3+j);
					cr_s1[i*3+j] <= 36'(em(wk.e, a1, wk.c_mag[a2*3+j]))
						+ 36'(em(wk.e, a2, wk.c_mag[a1*3+j]))
						+ 36'(em(wk.f, j1, wk.c_mag[i*3+j2]))
						+ 36'(em(wk.f, j2, wk.c_mag[i*3+j1]));
				end
			end
			face_ok_s1 <= ok;
			en_s1      <= wk.enabled;
			idx_s1     <= wk.index;
			last_s1    <= wk.last;
			par_s1     <= wk.parallel;
		end
	end

	// compare cross projections with scaled radii
	always_comb begin
		logic [66:0] m;
		cross_ok = 1'b1;
		for (int p = 0; p < 9; p++) begin
			m = cp_s1[p][66] ? 67'(-cp_s1[p]) : 67'(cp_s1[p]);
			if (m > (67'(cr_s1[p]) << 14)) cross_ok = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_o) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && v_s1) begin
			overlap   <= en_s1 && face_ok_s1 && (par_s1 || cross_ok);
			hit_index <= idx_s1;
			scan_end  <= last_s1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> v_s1) else $error("stage lost");
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_o && v_s1 && !en_s1) |=> !overlap) else $error("disabled overlap");

endmodule

>>> test/testbench.sv
// Self-checking bench for the oriented-box overlap test: a queue-fed driver,
// a monitor with its own separating-axis predictor, and APB register setup.
// Depends on obb_pkg and the obb_overlap_test RTL.
module testbench;
	import obb_pkg::*;

	typedef struct {
		logic signed [23:0] cx, cy, cz;
		logic [47:0]        a0, a1, a2, ext;
		logic               en;
		logic [9:0]         idx;
		logic               last;
	} cand_t;

	typedef struct {
		logic       hit;
		logic [9:0] idx;
		logic       last;
	} verdict_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_BITS-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [23:0] cand_center_x, cand_center_y, cand_center_z;
	logic [47:0] cand_axis_0, cand_axis_1, cand_axis_2, cand_extents;
	logic cand_enabled, cand_last;
	logic [INDEX_BITS-1:0] cand_index;
	logic overlap, scan_end;
	logic [INDEX_BITS-1:0] hit_index;

	obb_overlap_test u_top (.*);

	// reference box as the predictor sees it
	logic signed [23:0] rc_x, rc_y, rc_z;
	logic [47:0] ra_0, ra_1, ra_2, r_ext;

	cand_t    boxes_to_send[$];
	verdict_t verdicts_due[$];
	bit  took;
	bit  quiet, hold_go;
	int  hold_cnt;
	int  n_words, n_hits, n_results, n_bad;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint comp_of(logic [47:0] p, int k);
		return longint'($signed(p[16*k +: 16]));
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	// separating-axis test of one candidate against the reference box
	function automatic bit boxes_touch(cand_t b);
		longint ra[3][3], cb[3][3], c[3][3], ac[3][3];
		longint df[3], d[3], e[3], f[3];
		longint full, m, r, r0, r1;
		bit par;
		par = 0;
		for (int k = 0; k < 3; k++) begin
			ra[0][k] = comp_of(ra_0, k); ra[1][k] = comp_of(ra_1, k);
			ra[2][k] = comp_of(ra_2, k);
			cb[0][k] = comp_of(b.a0, k); cb[1][k] = comp_of(b.a1, k);
			cb[2][k] = comp_of(b.a2, k);
			e[k] = longint'(r_ext[16*k +: 16]);
			f[k] = longint'(b.ext[16*k +: 16]);
		end
		df[0] = longint'(rc_x) - longint'(b.cx);
		df[1] = longint'(rc_y) - longint'(b.cy);
		df[2] = longint'(rc_z) - longint'(b.cz);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				full = ra[i][0]*cb[j][0] + ra[i][1]*cb[j][1] + ra[i][2]*cb[j][2];
				m = (absl(full) + 8192) >>> 14;
				ac[i][j] = m;
				c[i][j] = full < 0 ? -m : m;
				if (m >= 16384) par = 1;
			end
			d[i] = df[0]*ra[i][0] + df[1]*ra[i][1] + df[2]*ra[i][2];
		end
		// reference faces, then candidate faces
		for (int i = 0; i < 3; i++) begin
			r1 = f[0]*ac[i][0] + f[1]*ac[i][1] + f[2]*ac[i][2];
			if (absl(d[i]) > (e[i] << 14) + r1) return 0;
		end
		for (int j = 0; j < 3; j++) begin
			r0 = e[0]*ac[0][j] + e[1]*ac[1][j] + e[2]*ac[2][j];
			r = df[0]*cb[j][0] + df[1]*cb[j][1] + df[2]*cb[j][2];
			if (absl(r) > r0 + (f[j] << 14)) return 0;
		end
		if (par) return 1;
		// edge cross axes
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				r  = absl(d[(i+2)%3]*c[(i+1)%3][j] - d[(i+1)%3]*c[(i+2)%3][j]);
				r0 = e[(i+1)%3]*ac[(i+2)%3][j] + e[(i+2)%3]*ac[(i+1)%3][j];
				r1 = f[(j+1)%3]*ac[i][(j+2)%3] + f[(j+2)%3]*ac[i][(j+1)%3];
				if (r > ((r0 + r1) << 14)) return 0;
			end
		return 1;
	endfunction

	// feed words, hold on stall
	always @(negedge clk or negedge arst_n) begin
		cand_t b;
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || took) begin
			if (boxes_to_send.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
				b = boxes_to_send.pop_front();
				cand_center_x <= b.cx; cand_center_y <= b.cy; cand_center_z <= b.cz;
				cand_axis_0 <= b.a0; cand_axis_1 <= b.a1; cand_axis_2 <= b.a2;
				cand_extents <= b.ext; cand_enabled <= b.en;
				cand_index <= b.idx; cand_last <= b.last;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver stall: long hold-off on request, else random
	always @(negedge clk) begin
		if (hold_go && hold_cnt < 300) begin
			out_stall <= 1;
			hold_cnt++;
		end else begin
			out_stall <= !quiet && $urandom_range(99) < 6;
		end
	end

	// record accepted words, check results
	always @(posedge clk) begin
		cand_t b;
		verdict_t v;
		took = arst_n && in_valid && !in_stall;
		if (took) begin
			b = '{cand_center_x, cand_center_y, cand_center_z, cand_axis_0,
				cand_axis_1, cand_axis_2, cand_extents, cand_enabled,
				cand_index, cand_last};
			v.hit = cand_enabled && boxes_touch(b);
			v.idx = cand_index;
			v.last = cand_last;
			verdicts_due.push_back(v);
			n_words++;
			if (v.hit) n_hits++;
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (verdicts_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result idx=%0d", hit_index);
			end else begin
				v = verdicts_due.pop_front();
				if (v.hit !== overlap || v.idx !== hit_index || v.last !== scan_end) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: exp ov=%0b idx=%0d end=%0b got ov=%0b idx=%0d end=%0b",
							v.hit, v.idx, v.last, overlap, hit_index, scan_end);
				end
			end
		end
	end

	function automatic logic [47:0] pack3(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	// orthonormal basis presets, axis k of preset s
	function automatic logic [47:0] basis(int s, int k, int jit);
		int m[4][3][3];
		m[0] = '{'{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384}};
		m[1] = '{'{11585, 11585, 0}, '{-11585, 11585, 0}, '{0, 0, 16384}};
		m[2] = '{'{16384, 0, 0}, '{0, 14189, 8192}, '{0, -8192, 14189}};
		m[3] = '{'{11585, 8192, 8192}, '{-11585, 8192, 8192}, '{0, -11585, 11585}};
		return pack3(m[s][k][0] + $urandom_range(2*jit) - jit,
			m[s][k][1] + $urandom_range(2*jit) - jit,
			m[s][k][2] + $urandom_range(2*jit) - jit);
	endfunction

	task automatic cfg(reg_addr_t a, logic [63:0] v);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = a; pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		case (a)
			REG_CENTER_X: rc_x = v[23:0];
			REG_CENTER_Y: rc_y = v[23:0];
			REG_CENTER_Z: rc_z = v[23:0];
			REG_AXIS_0:   ra_0 = v[47:0];
			REG_AXIS_1:   ra_1 = v[47:0];
			REG_AXIS_2:   ra_2 = v[47:0];
			REG_EXTENTS:  r_ext = v[47:0];
			default: ;
		endcase
	endtask

	task automatic set_ref(int cx, int cy, int cz, int s, int jit, logic [47:0] ext);
		cfg(REG_CENTER_X, 64'(cx)); cfg(REG_CENTER_Y, 64'(cy));
		cfg(REG_CENTER_Z, 64'(cz));
		cfg(REG_AXIS_0, 64'(basis(s, 0, jit))); cfg(REG_AXIS_1, 64'(basis(s, 1, jit)));
		cfg(REG_AXIS_2, 64'(basis(s, 2, jit))); cfg(REG_EXTENTS, 64'(ext));
	endtask

	task automatic add(int dx, int dy, int dz, int s, int jit, logic [47:0] ext,
			logic en, logic [9:0] idx, logic last);
		cand_t b;
		b.cx = 24'(rc_x + dx); b.cy = 24'(rc_y + dy); b.cz = 24'(rc_z + dz);
		b.a0 = basis(s, 0, jit); b.a1 = basis(s, 1, jit); b.a2 = basis(s, 2, jit);
		b.ext = ext; b.en = en; b.idx = idx; b.last = last;
		boxes_to_send.push_back(b);
	endtask

	// mostly well-formed boxes near the reference, some pure noise
	task automatic add_random(int n, int reach);
		cand_t b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 2) begin
				b.cx = 24'($urandom); b.cy = 24'($urandom); b.cz = 24'($urandom);
				b.a0 = 48'({$urandom, $urandom}); b.a1 = 48'({$urandom, $urandom});
				b.a2 = 48'({$urandom, $urandom}); b.ext = 48'({$urandom, $urandom});
				b.en = 1'($urandom); b.idx = 10'($urandom); b.last = 1'($urandom);
				boxes_to_send.push_back(b);
			end else begin
				add($urandom_range(2*reach) - reach, $urandom_range(2*reach) - reach,
					$urandom_range(2*reach) - reach, $urandom_range(3),
					$urandom_range(1) ? 0 : 300,
					{16'($urandom_range(1536)), 16'($urandom_range(1536)),
					16'($urandom_range(1536))},
					$urandom_range(15) != 0, 10'($urandom), $urandom_range(7) == 0);
			end
		end
	endtask

	// wait until everything queued has come back, then let the pipe settle
	task automatic drain;
		while (boxes_to_send.size() > 0 || in_valid || verdicts_due.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		out_stall = 0; quiet = 0; hold_go = 0; hold_cnt = 0;
		cand_center_x = 0; cand_center_y = 0; cand_center_z = 0;
		cand_axis_0 = 0; cand_axis_1 = 0; cand_axis_2 = 0; cand_extents = 0;
		cand_enabled = 0; cand_index = 0; cand_last = 0;
		rc_x = 0; rc_y = 0; rc_z = 0;
		ra_0 = pack3(16384, 0, 0); ra_1 = pack3(0, 16384, 0); ra_2 = pack3(0, 0, 16384);
		r_ext = 0;
		n_words = 0; n_hits = 0; n_results = 0; n_bad = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// reset-state reference: point box at origin
		add(0, 0, 0, 0, 0, 48'h0001_0001_0001, 1, 0, 0);
		add(0, 0, 0, 1, 0, 48'h0, 1, 1023, 1);
		add(300, 0, 0, 0, 0, 48'h0001_0001_0001, 1, 5, 0);
		drain();

		// directed: rotated reference, parallel, cross axes, disabled, extremes
		set_ref(256, -512, 768, 3, 0, 48'h0200_0300_0400);
		add(0, 0, 0, 3, 0, 48'h0100_0100_0100, 1, 1, 0);
		add(0, 0, 0, 3, 0, 48'h0100_0100_0100, 0, 2, 1);
		add(2500, 0, 0, 3, 0, 48'h0100_0100_0100, 1, 3, 0);
		add(0, 0, 0, 1, 0, 48'h0100_0100_0100, 1, 4, 0);
		add(1600, 1600, 0, 2, 0, 48'h0080_0200_0080, 1, 5, 0);
		add(1400, -1400, 900, 1, 0, 48'h0300_0040_0300, 1, 6, 0);
		add(900, 900, 900, 2, 0, 48'h0100_0100_0100, 1, 7, 0);
		add(0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1, 1023, 1);
		begin
			cand_t b;
			b = '{24'sh800000, 24'sh800000, 24'sh800000, 48'h8000_8000_8000,
				48'h8000_8000_8000, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF, 1, 0, 1};
			boxes_to_send.push_back(b);
			b = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 48'h7FFF_7FFF_7FFF,
				48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h0, 1, 1023, 0};
			boxes_to_send.push_back(b);
			b = '{24'sh7FFFFF, 24'sh800000, 24'sh0, 48'h0, 48'h0, 48'h0,
				48'hFFFF_FFFF_FFFF, 1, 512, 1};
			boxes_to_send.push_back(b);
		end
		drain();
		add_random(230, 4096);
		drain();

		// extreme reference, no idling at all
		quiet = 1;
		cfg(REG_CENTER_X, 64'h7FFFFF); cfg(REG_CENTER_Y, 64'h800000);
		cfg(REG_CENTER_Z, 64'h7FFFFF);
		cfg(REG_AXIS_0, 64'h8000_8000_8000); cfg(REG_AXIS_1, 64'h7FFF_7FFF_7FFF);
		cfg(REG_AXIS_2, 64'h0000_8000_7FFF); cfg(REG_EXTENTS, 64'hFFFF_FFFF_FFFF);
		add_random(120, 65536);
		drain();
		quiet = 0;

		// skewed reference with jitter; long receiver hold-off fills the pipe
		set_ref(-4096, 2048, 0, 2, 300, 48'h0500_0080_0300);
		hold_go = 1;
		add_random(240, 3000);
		drain();

		$display("covered %0d candidates, %0d overlaps, %0d results checked, %0d bad",
			n_words, n_hits, n_results, n_bad);
		if (n_bad == 0 && verdicts_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
